>>> design/aes_pkg.sv
`default_nettype none
package aes_pkg;

    typedef struct packed {
        logic        func;
        logic [63:0] block_hi;
        logic [63:0] block_lo;
    } t_in_item;

    typedef struct packed {
        logic [63:0] result_hi;
        logic [63:0] result_lo;
    } t_out_item;

    localparam logic [2:0] REG_KEY_SIZE = 3'd0;
    localparam logic [2:0] REG_KEY_W0   = 3'd1;
    localparam logic [2:0] REG_KEY_W1   = 3'd2;
    localparam logic [2:0] REG_KEY_W2   = 3'd3;
    localparam logic [2:0] REG_KEY_W3   = 3'd4;

    localparam logic [1:0] KS_128 = 2'd0;
    localparam logic [1:0] KS_192 = 2'd1;
    localparam logic [1:0] KS_256 = 2'd2;

    localparam int NUM_KEYS = 15;

    function automatic logic [7:0] xt(input logic [7:0] a);
        xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        sbox = t[a];
    endfunction

    function automatic logic [7:0] isbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
        isbox = t[a];
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    // SubBytes, ShiftRows, MixColumns (unless last) on a 128-bit state, byte 0 in bits 127:120
    function automatic logic [127:0] enc_round(input logic [127:0] s, input logic last);
        logic [7:0] b [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3;
        logic [127:0] o;
        for (int i = 0; i < 16; i++) b[i] = sbox(s[127-8*i -: 8]);
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++) t[r+4*c] = b[r+4*((c+r)%4)];
        for (int c = 0; c < 4; c++) begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            if (!last) begin
                t[4*c]   = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
                t[4*c+1] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
                t[4*c+2] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
                t[4*c+3] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
            end
        end
        for (int i = 0; i < 16; i++) o[127-8*i -: 8] = t[i];
        enc_round = o;
    endfunction

    // inverse: InvMixColumns (unless first), InvShiftRows, InvSubBytes
    function automatic logic [127:0] dec_round(input logic [127:0] s, input logic first);
        logic [7:0] b [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, u, v;
        logic [127:0] o;
        for (int i = 0; i < 16; i++) b[i] = s[127-8*i -: 8];
        if (!first) begin
            for (int c = 0; c < 4; c++) begin
                a0 = b[4*c]; a1 = b[4*c+1]; a2 = b[4*c+2]; a3 = b[4*c+3];
                u = xt(xt(a0 ^ a2));
                v = xt(xt(a1 ^ a3));
                a0 = a0 ^ u; a1 = a1 ^ v; a2 = a2 ^ u; a3 = a3 ^ v;
                b[4*c]   = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
                b[4*c+1] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
                b[4*c+2] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
                b[4*c+3] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
            end
        end
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++) t[r+4*c] = isbox(b[r+4*((c+3*r)%4)]);
        for (int i = 0; i < 16; i++) o[127-8*i -: 8] = t[i];
        dec_round = o;
    endfunction

endpackage
`default_nettype wire

>>> design/aes_block_cipher_top.sv
// AES-128/192/256 block cipher, fully pipelined.
// Configuration channel (i_cfg_valid/o_cfg_ready, i_cfg_index, i_cfg_data) sets the
// key size (index 0) and the four 64-bit key words (1..4); o_cfg_ready is always
// high. After any write the round keys are expanded one schedule word per cycle:
// 44, 52 or 60 words for a 128, 192 or 256-bit key, with o_in_stall held high.
// The user must write configuration only while no block is in flight; not enforced.
// Input channel: i_in_valid, o_in_stall, i_in_data (func, block). A transfer
// happens when valid is high and stall is low.
// Output channel: o_out_valid, i_out_stall, o_out_data.
// Pipeline: 16 stages; stage 0 adds the first key, stages 1..14 run one round each
// (rounds past Nr pass through) and stage 15 only registers. One block can enter
// every cycle while o_in_stall is low. When the receiver stalls the whole pipeline
// freezes and o_in_stall rises in the same cycle; nothing is lost.
// Reset clears valid bits and key registers and starts an expansion of the
// all-zero 128-bit key.
`default_nettype none
module aes_block_cipher_top (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire  [2:0]               i_cfg_index,
    input  wire  [63:0]              i_cfg_data,
    input  wire                      i_in_valid,
    output logic                     o_in_stall,
    input  wire  aes_pkg::t_in_item  i_in_data,
    output logic                     o_out_valid,
    input  wire                      i_out_stall,
    output aes_pkg::t_out_item       o_out_data
);
    localparam int NS = 16;

    logic [1:0]   r_key_size;
    logic [63:0]  r_kw  [4];
    logic [127:0] r_rk  [aes_pkg::NUM_KEYS];
    logic [31:0]  r_win [8];
    logic [5:0]   r_exp_i;
    logic         r_exp_busy;
    logic [7:0]   r_rc;
    logic [3:0]   r_nk_cnt;

    logic [3:0]  nk;
    logic [3:0]  nr;
    logic [5:0]  total;
    logic [31:0] prev_w, tw, new_w;
    logic        cfg_fire;

    assign o_cfg_ready = 1'b1;
    assign cfg_fire    = i_cfg_valid;

    always_comb begin
        unique case (r_key_size)
            aes_pkg::KS_128: begin nk = 4'd4; nr = 4'd10; total = 6'd44; end
            aes_pkg::KS_192: begin nk = 4'd6; nr = 4'd12; total = 6'd52; end
            default:         begin nk = 4'd8; nr = 4'd14; total = 6'd60; end
        endcase
    end

    // schedule word r_exp_i; r_nk_cnt is r_exp_i mod nk; r_win[k] is word r_exp_i-1-k
    always_comb begin
        prev_w = r_win[0];
        tw     = prev_w;
        if (r_nk_cnt == 4'd0)
            tw = aes_pkg::sub_word({prev_w[23:0], prev_w[31:24]}) ^ {r_rc, 24'd0};
        else if (nk == 4'd8 && r_nk_cnt == 4'd4)
            tw = aes_pkg::sub_word(prev_w);
        if (r_exp_i < {2'd0, nk})
            new_w = r_exp_i[0] ? r_kw[r_exp_i[2:1]][31:0] : r_kw[r_exp_i[2:1]][63:32];
        else
            new_w = r_win[3'(nk - 4'd1)] ^ tw;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_size <= aes_pkg::KS_128;
            for (int i = 0; i < 4; i++) r_kw[i] <= 64'd0;
            r_exp_i    <= 6'd0;
            r_exp_busy <= 1'b1;
            r_rc       <= 8'h01;
            r_nk_cnt   <= 4'd0;
        end else if (cfg_fire) begin
            unique case (i_cfg_index)
                aes_pkg::REG_KEY_SIZE: r_key_size <= (i_cfg_data[1:0] > aes_pkg::KS_256)
                                                     ? aes_pkg::KS_256 : i_cfg_data[1:0];
                aes_pkg::REG_KEY_W0: r_kw[0] <= i_cfg_data;
                aes_pkg::REG_KEY_W1: r_kw[1] <= i_cfg_data;
                aes_pkg::REG_KEY_W2: r_kw[2] <= i_cfg_data;
                aes_pkg::REG_KEY_W3: r_kw[3] <= i_cfg_data;
                default: ;
            endcase
            r_exp_i    <= 6'd0;
            r_exp_busy <= 1'b1;
            r_rc       <= 8'h01;
            r_nk_cnt   <= 4'd0;
        end else if (r_exp_busy) begin
            r_rk[r_exp_i[5:2]][(7'd96 - {r_exp_i[1:0], 5'd0}) +: 32] <= new_w;
            r_win[0] <= new_w;
            for (int k = 1; k < 8; k++) r_win[k] <= r_win[k-1];
            if (r_exp_i >= {2'd0, nk} && r_nk_cnt == 4'd0) r_rc <= aes_pkg::xt(r_rc);
            r_nk_cnt <= (r_nk_cnt == nk - 4'd1) ? 4'd0 : r_nk_cnt + 4'd1;
            if (r_exp_i == total - 6'd1) r_exp_busy <= 1'b0;
            r_exp_i <= r_exp_i + 6'd1;
        end
    end

    // pipeline
    logic           r_v   [NS];
    logic           r_f   [NS];
    logic [127:0]   r_s   [NS];
    logic           adv;

    assign adv        = !(o_out_valid && i_out_stall);
    assign o_in_stall = !adv || r_exp_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < NS; j++) r_v[j] <= 1'b0;
        end else if (adv) begin
            r_v[0] <= i_in_valid && !r_exp_busy;
            for (int j = 1; j < NS; j++) r_v[j] <= r_v[j-1];
        end
    end

    // stage 0 adds the first key; stage j (1..nr) runs round j; stage 15 only registers
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_f[0] <= i_in_data.func;
            r_s[0] <= {i_in_data.block_hi, i_in_data.block_lo}
                      ^ (i_in_data.func ? r_rk[nr] : r_rk[0]);
            for (int j = 1; j < NS - 1; j++) begin
                r_f[j] <= r_f[j-1];
                if (j[3:0] > nr) begin
                    r_s[j] <= r_s[j-1];
                end else if (!r_f[j-1]) begin
                    r_s[j] <= aes_pkg::enc_round(r_s[j-1], j[3:0] == nr) ^ r_rk[j[3:0]];
                end else begin
                    // decrypt round j uses key nr-j
                    r_s[j] <= aes_pkg::dec_round(r_s[j-1], j == 1) ^ r_rk[nr - j[3:0]];
                end
            end
            r_f[NS-1] <= r_f[NS-2];
            r_s[NS-1] <= r_s[NS-2];
        end
    end

    assign o_out_valid           = r_v[NS-1];
    assign o_out_data.result_hi  = r_s[NS-1][127:64];
    assign o_out_data.result_lo  = r_s[NS-1][63:0];

    a_no_entry_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_exp_busy |-> o_in_stall) else $error("entry during expansion");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid) else $error("output dropped");
    a_exp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_exp_busy |-> r_exp_i < 6'd60) else $error("expansion index");
endmodule
`default_nettype wire

>>> dv/aes_block_cipher_checker.sv
`default_nettype none
module aes_block_cipher_checker (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_cfg_valid,
    input  wire                      i_cfg_ready,
    input  wire  [2:0]               i_cfg_index,
    input  wire  [63:0]              i_cfg_data,
    input  wire                      i_in_valid,
    input  wire                      i_in_stall,
    input  wire  aes_pkg::t_in_item  i_in_data,
    input  wire                      i_out_valid,
    input  wire                      i_out_stall,
    input  wire  aes_pkg::t_out_item i_out_data,
    output int                       o_fail_count,
    output int                       o_pending
);
    logic [1:0]         key_len;
    logic [63:0]        key_reg [4];
    logic [31:0]        sched [60];
    aes_pkg::t_out_item block_q [$];

    initial o_fail_count = 0;
    initial o_pending = 0;

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) acc ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return acc;
    endfunction

    function automatic logic [7:0] fwd_byte(input logic [7:0] a);
        logic [7:0] inv;
        logic [7:0] r;
        inv = 8'h00;
        for (int k = 1; k < 256; k++)
            if (gmul(a, k[7:0]) == 8'h01) inv = k[7:0];
        r = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
            ^ {inv[3:0], inv[7:4]} ^ 8'h63;
        return r;
    endfunction

    logic [7:0] fwd_tab [256];
    logic [7:0] inv_tab [256];
    initial begin
        for (int i = 0; i < 256; i++) begin
            fwd_tab[i] = fwd_byte(i[7:0]);
            inv_tab[fwd_tab[i]] = i[7:0];
        end
    end

    function automatic logic [31:0] sub4(input logic [31:0] w);
        return {fwd_tab[w[31:24]], fwd_tab[w[23:16]], fwd_tab[w[15:8]], fwd_tab[w[7:0]]};
    endfunction

    function automatic int expand_schedule();
        int nk, nr;
        logic [1:0] sel;
        logic [7:0] rc;
        logic [31:0] t;
        sel = (key_len > aes_pkg::KS_256) ? aes_pkg::KS_256 : key_len;
        nk = 4 + 2 * sel;
        nr = nk + 6;
        rc = 8'h01;
        for (int i = 0; i < nk; i++)
            sched[i] = i[0] ? key_reg[i >> 1][31:0] : key_reg[i >> 1][63:32];
        for (int i = nk; i < 4 * (nr + 1); i++) begin
            t = sched[i-1];
            if (i % nk == 0) begin
                t = sub4({t[23:0], t[31:24]}) ^ {rc, 24'h0};
                rc = gmul(rc, 8'h02);
            end else if (nk > 6 && i % nk == 4) begin
                t = sub4(t);
            end
            sched[i] = sched[i-nk] ^ t;
        end
        return nr;
    endfunction

    function automatic aes_pkg::t_out_item cipher_block(input aes_pkg::t_in_item it);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] col [4];
        logic [7:0] fc [4];
        logic [7:0] ic [4];
        logic [127:0] blk;
        logic [127:0] o;
        int nr, rr;
        fc = '{8'h02, 8'h03, 8'h01, 8'h01};
        ic = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
        blk = {it.block_hi, it.block_lo};
        for (int i = 0; i < 16; i++) s[i] = blk[127-8*i -: 8];
        nr = expand_schedule();
        for (int step = 0; step <= nr; step++) begin
            rr = it.func ? nr - step : step;
            if (step > 0) begin
                if (!it.func) begin
                    for (int i = 0; i < 16; i++) s[i] = fwd_tab[s[i]];
                    for (int r = 0; r < 4; r++)
                        for (int c = 0; c < 4; c++) t[r+4*c] = s[r+4*((c+r)%4)];
                    s = t;
                    if (step < nr)
                        for (int c = 0; c < 4; c++) begin
                            for (int r = 0; r < 4; r++) col[r] = s[4*c+r];
                            for (int r = 0; r < 4; r++)
                                s[4*c+r] = gmul(col[0], fc[(4-r)&3]) ^ gmul(col[1], fc[(5-r)&3])
                                    ^ gmul(col[2], fc[(6-r)&3]) ^ gmul(col[3], fc[(7-r)&3]);
                        end
                end else begin
                    if (step > 1)
                        for (int c = 0; c < 4; c++) begin
                            for (int r = 0; r < 4; r++) col[r] = s[4*c+r];
                            for (int r = 0; r < 4; r++)
                                s[4*c+r] = gmul(col[0], ic[(4-r)&3]) ^ gmul(col[1], ic[(5-r)&3])
                                    ^ gmul(col[2], ic[(6-r)&3]) ^ gmul(col[3], ic[(7-r)&3]);
                        end
                    for (int r = 0; r < 4; r++)
                        for (int c = 0; c < 4; c++) t[r+4*c] = inv_tab[s[r+4*((c+3*r)%4)]];
                    s = t;
                end
            end
            for (int c = 0; c < 4; c++)
                for (int b = 0; b < 4; b++)
                    s[4*c+b] ^= sched[4*rr+c][31-8*b -: 8];
        end
        for (int i = 0; i < 16; i++) o[127-8*i -: 8] = s[i];
        return o;
    endfunction

    aes_pkg::t_out_item want;
    int                 errs;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            key_len <= aes_pkg::KS_128;
            for (int i = 0; i < 4; i++) key_reg[i] <= '0;
        end else begin
            errs = 0;
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    aes_pkg::REG_KEY_SIZE: key_len <= i_cfg_data[1:0];
                    aes_pkg::REG_KEY_W0:   key_reg[0] <= i_cfg_data;
                    aes_pkg::REG_KEY_W1:   key_reg[1] <= i_cfg_data;
                    aes_pkg::REG_KEY_W2:   key_reg[2] <= i_cfg_data;
                    aes_pkg::REG_KEY_W3:   key_reg[3] <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                block_q.insert(block_q.size(), cipher_block(i_in_data));
            if (i_out_valid && !i_out_stall) begin
                if (block_q.size() == 0) begin
                    $error("unexpected transfer: result_hi=%h result_lo=%h",
                        i_out_data.result_hi, i_out_data.result_lo);
                    errs = errs + 1;
                end else begin
                    want = block_q.pop_front();
                    if (want.result_hi !== i_out_data.result_hi) begin
                        $error("result_hi: expected %h actual %h",
                            want.result_hi, i_out_data.result_hi);
                        errs = errs + 1;
                    end
                    if (want.result_lo !== i_out_data.result_lo) begin
                        $error("result_lo: expected %h actual %h",
                            want.result_lo, i_out_data.result_lo);
                        errs = errs + 1;
                    end
                end
            end
            o_fail_count <= o_fail_count + errs;
            o_pending    <= block_q.size();
        end
    end
endmodule
`default_nettype wire

>>> dv/tb_aes_block_cipher_top.sv
`default_nettype none
module tb_aes_block_cipher_top;
    logic               i_clk;
    logic               i_rst_n;
    logic               cfg_valid;
    wire                cfg_ready;
    logic [2:0]         cfg_index;
    logic [63:0]        cfg_data;
    logic               in_valid;
    wire                in_stall;
    aes_pkg::t_in_item  in_data;
    wire                out_valid;
    logic               out_stall;
    aes_pkg::t_out_item out_data;
    int                 fail_count;
    int                 pending;
    logic               hold_out;

    aes_block_cipher_top i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_data(out_data)
    );

    aes_block_cipher_checker i_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_data(out_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 40) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [63:0] rnd64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] field_pick();
        case ($urandom_range(0, 5))
            0: return 64'h0;
            1: return '1;
            2: return 64'h8000_0000_0000_0000;
            default: return rnd64();
        endcase
    endfunction

    // leaves cfg_valid high; the caller drops it
    task automatic cfg_write(input logic [2:0] idx, input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
    endtask

    // leaves in_valid high; the caller drops it
    task automatic send_block(input logic f, input logic [63:0] hi, input logic [63:0] lo);
        in_valid <= 1'b1;
        in_data  <= '{func: f, block_hi: hi, block_lo: lo};
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic load_key(input logic [1:0] ks, input logic [63:0] k0, input logic [63:0] k1,
                            input logic [63:0] k2, input logic [63:0] k3);
        cfg_write(aes_pkg::REG_KEY_SIZE, {62'h0, ks});
        cfg_write(aes_pkg::REG_KEY_W0, k0);
        cfg_write(aes_pkg::REG_KEY_W1, k1);
        cfg_write(aes_pkg::REG_KEY_W2, k2);
        cfg_write(aes_pkg::REG_KEY_W3, k3);
        cfg_valid <= 1'b0;
    endtask

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_out) begin
                out_stall <= 1'b1;
                repeat (120) @(posedge i_clk);
                out_stall <= 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                out_stall <= 1'b1;
                repeat (gap_len()) @(posedge i_clk);
                out_stall <= 1'b0;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    initial begin
        #50_000_000;
        $display("FAIL aes_block_cipher_top");
        $finish;
    end

    initial begin
        int g;
        logic [1:0] ks;
        cfg_valid = 1'b0;
        cfg_index = aes_pkg::REG_KEY_SIZE;
        cfg_data  = '0;
        in_valid  = 1'b0;
        in_data   = '0;
        hold_out  = 1'b0;
        i_rst_n   = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // FIPS-197 appendix C vectors, extremes, saturated key size
        load_key(aes_pkg::KS_128, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, '1, '1);
        send_block(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff);
        send_block(1'b1, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
        send_block(1'b0, '0, '0);
        send_block(1'b1, '1, '1);
        drain();
        load_key(aes_pkg::KS_192, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                 64'h1011121314151617, '1);
        send_block(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff);
        send_block(1'b1, 64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191);
        send_block(1'b0, '1, '0);
        drain();
        load_key(aes_pkg::KS_256, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                 64'h1011121314151617, 64'h18191a1b1c1d1e1f);
        send_block(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff);
        send_block(1'b1, 64'h8ea2b7ca516745bf, 64'heafc49904b496089);
        drain();
        load_key('1, '1, '1, '1, '1);
        send_block(1'b0, '0, '1);
        send_block(1'b1, '1, '0);
        drain();
        cfg_write(aes_pkg::REG_KEY_W3 + 3'd1, '1);
        cfg_write('1, '0);
        load_key(aes_pkg::KS_128, '0, '0, '0, '0);
        send_block(1'b0, '0, '0);
        send_block(1'b1, '0, '0);
        drain();

        // long receiver hold-off while the sender keeps offering
        hold_out <= 1'b1;
        fork
            begin
                repeat (50) @(posedge i_clk);
                hold_out <= 1'b0;
            end
        join_none
        for (int i = 0; i < 40; i++) send_block(1'($urandom_range(0, 1)), rnd64(), rnd64());
        drain();

        for (int ph = 0; ph < 16; ph++) begin
            ks = (ph < 4) ? ph[1:0] : 2'($urandom_range(0, 3));
            load_key(ks, field_pick(), field_pick(), field_pick(), field_pick());
            for (int i = 0; i < 100; i++) begin
                g = ($urandom_range(0, 2) == 0) ? gap_len() : 0;
                if (g > 0) begin
                    in_valid <= 1'b0;
                    repeat (g) @(posedge i_clk);
                end
                send_block(1'($urandom_range(0, 1)), field_pick(), field_pick());
                if (i == 50) begin
                    in_valid <= 1'b0;
                    @(posedge i_clk);
                    while (pending != 0) @(posedge i_clk);
                end
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("PASS aes_block_cipher_top");
        end else begin
            $display("FAIL aes_block_cipher_top");
        end
        $finish;
    end
endmodule
`default_nettype wire

>>> files.f
design/aes_pkg.sv
design/aes_block_cipher_top.sv
dv/aes_block_cipher_checker.sv
dv/tb_aes_block_cipher_top.sv
